[rtl/lard_pkg.sv]
// ----------------------------------------------------------------------------
// lard_pkg: shared types and constants of the load-aware request dispatcher
// Field widths, register codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lard_pkg;

    localparam int MAX_BACKENDS = 16;
    localparam int LOAD_BITS    = 20;

    // Fixed field widths of the channels.
    localparam int ACTION_W = 1;
    localparam int TARGET_W = 4;
    localparam int AMOUNT_W = 20;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Derived internal widths.
    localparam int IDX_W  = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int CNT_W  = $clog2(MAX_BACKENDS + 1);
    localparam int CALC_W = ((LOAD_BITS > AMOUNT_W) ? LOAD_BITS : AMOUNT_W) + 1;

    localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;
    localparam logic [COUNT_W-1:0]   COUNT_RESET = COUNT_W'(16);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ROUTE = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MODE   = 1'b0,
        CFG_BACKEND_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        POLICY_ROUND_ROBIN  = 1'b0,
        POLICY_LEAST_LOADED = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RR_PICK,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_READ,
        ST_ADD,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic rr_pick;
        logic scan_issue;
        logic sel_read;
        logic do_add;
        logic do_write;
        logic out_load;
    } lard_cmd_t;

    typedef struct packed {
        logic    is_write;
        policy_t policy;
        logic    scan_last;
        logic    out_free;
    } lard_status_t;

    // Number of backends in use: zero acts as one, and the count is capped
    // at the size of the load store.
    function automatic logic [CNT_W-1:0] active_count(logic [COUNT_W-1:0] c);
        int v;
        v = int'(c);
        if (v == 0)
        begin
            v = 1;
        end
        if (v > MAX_BACKENDS)
        begin
            v = MAX_BACKENDS;
        end
        return CNT_W'(v);
    endfunction

endpackage

[rtl/lard_req_if.sv]
// ----------------------------------------------------------------------------
// lard_req_if: request channel
// Valid/ready channel carrying one dispatcher request item.
// ----------------------------------------------------------------------------
interface lard_req_if;
    import lard_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TARGET_W-1:0] target_index;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output action, output target_index,
                    output amount, input ready);
    modport sink   (input valid, input action, input target_index,
                    input amount, output ready);
endinterface

[rtl/lard_rsp_if.sv]
// ----------------------------------------------------------------------------
// lard_rsp_if: result channel
// Valid/ready channel carrying one dispatcher result item.
// ----------------------------------------------------------------------------
interface lard_rsp_if;
    import lard_pkg::*;

    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] chosen_backend;
    logic [AMOUNT_W-1:0] new_load;
    logic                saturated;

    modport source (output valid, output chosen_backend, output new_load,
                    output saturated, input ready);
    modport sink   (input valid, input chosen_backend, input new_load,
                    input saturated, output ready);
endinterface

[rtl/lard_cfg_if.sv]
// ----------------------------------------------------------------------------
// lard_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface lard_cfg_if;
    import lard_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/load_aware_request_dispatcher.sv]
// ----------------------------------------------------------------------------
// load_aware_request_dispatcher: round-robin and least-loaded dispatcher
// Routes each request to one backend, keeps a saturating load counter per
// backend and reports the chosen backend with its new load.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  -------  ---------  ------------------------------------------------------
//  req      in         action, target_index, amount (one item per request)
//  rsp      out        chosen_backend, new_load, saturated (one per item)
//  cfg      in         index, data (0: policy_mode, 1: backend_count)
//
// A load write passes through the write and finish states, a round-robin
// request through the pick, read, add and finish states, and a least-loaded
// request through the scan, last-scan, read, add and finish states; the scan
// reads the load store one entry per cycle through its single read port, over
// the N backends in use. A new item is taken only in the idle state, once the
// result of the last one has been loaded into the output register.
// Reset clears the configuration, the rotation pointer and the per-entry
// valid bits, so every load reads as zero right after reset; no clearing
// pass is needed. A stalled result sits in the output register while the
// block is already ready for the next item; that item completes once the
// register is free.
//
module load_aware_request_dispatcher (
    input logic         clk,
    input logic         rst_n,
    lard_req_if.sink    req,
    lard_rsp_if.source  rsp,
    lard_cfg_if.sink    cfg
);
    import lard_pkg::*;

    lard_cmd_t    cmd;
    lard_status_t status;
    logic         in_ready;

    // Configuration writes are taken at any time.
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    // The controller only sequences; all state of the item lives in the
    // datapath.
    lard_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lard_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .in_action          (req.action),
        .in_target_index    (req.target_index),
        .in_amount          (req.amount),
        .cfg_we             (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_chosen_backend (rsp.chosen_backend),
        .out_new_load       (rsp.new_load),
        .out_saturated      (rsp.saturated)
    );
endmodule

[rtl/lard_ram.sv]
// ----------------------------------------------------------------------------
// lard_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/lard_ctrl.sv]
// ----------------------------------------------------------------------------
// lard_ctrl: dispatcher controller
// State machine that sequences the pick, the load update and the result.
// ----------------------------------------------------------------------------
module lard_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lard_pkg::lard_status_t status,
    output lard_pkg::lard_cmd_t    cmd
);
    import lard_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.is_write)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (status.policy == POLICY_LEAST_LOADED)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RR_PICK;
                    end
                end
            end
            ST_RR_PICK:   state_next = ST_READ;
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST: state_next = ST_READ;
            ST_READ:      state_next = ST_ADD;
            ST_ADD:       state_next = ST_FINISH;
            ST_WRITE:     state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_item = in_valid;
            end
            ST_RR_PICK:   cmd.rr_pick    = 1'b1;
            ST_SCAN:      cmd.scan_issue = 1'b1;
            ST_SCAN_LAST: cmd            = '0;
            ST_READ:      cmd.sel_read   = 1'b1;
            ST_ADD:       cmd.do_add     = 1'b1;
            ST_WRITE:     cmd.do_write   = 1'b1;
            ST_FINISH:    cmd.out_load   = status.out_free;
            default:      cmd            = '0;
        endcase
    end
endmodule

[rtl/lard_dp.sv]
// ----------------------------------------------------------------------------
// lard_dp: dispatcher datapath
// Configuration registers, load store, scan and pick logic, saturating
// update and the output register.
// ----------------------------------------------------------------------------
module lard_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lard_pkg::lard_cmd_t             cmd,
    output lard_pkg::lard_status_t          status,
    input  logic [lard_pkg::ACTION_W-1:0]   in_action,
    input  logic [lard_pkg::TARGET_W-1:0]   in_target_index,
    input  logic [lard_pkg::AMOUNT_W-1:0]   in_amount,
    input  logic                            cfg_we,
    input  logic [lard_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lard_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lard_pkg::TARGET_W-1:0]   out_chosen_backend,
    output logic [lard_pkg::AMOUNT_W-1:0]   out_new_load,
    output logic                            out_saturated
);
    import lard_pkg::*;

    // Configuration.
    policy_t             policy_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]    n_active;

    // Latched item.
    logic [TARGET_W-1:0] target_reg;
    logic [AMOUNT_W-1:0] amount_reg;

    // Pick and scan state.
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     sel_idx_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic                 cmp_pend_reg;
    logic [LOAD_BITS-1:0] best_load_reg;
    logic [MAX_BACKENDS-1:0] valid_reg;

    // Result staging and output register.
    logic [TARGET_W-1:0] res_idx_reg;
    logic [AMOUNT_W-1:0] res_load_reg;
    logic                res_sat_reg;
    logic                out_valid_reg;
    logic [TARGET_W-1:0] out_idx_reg;
    logic [AMOUNT_W-1:0] out_load_reg;
    logic                out_sat_reg;

    // Store ports.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [LOAD_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [LOAD_BITS-1:0] ram_rdata;
    logic [LOAD_BITS-1:0] eff_load;

    // Combinational helpers.
    logic [IDX_W-1:0]     rr_pick;
    logic [IDX_W-1:0]     rr_ptr_next;
    logic [CALC_W-1:0]    add_sum;
    logic                 add_sat;
    logic [LOAD_BITS-1:0] add_load;
    logic                 wr_in_range;
    logic                 wr_sat;
    logic [LOAD_BITS-1:0] wr_load;

    assign n_active = active_count(count_reg);

    lard_ram #(
        .WIDTH (LOAD_BITS),
        .DEPTH (MAX_BACKENDS)
    ) u_load_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign eff_load  = valid_reg[rd_addr_reg] ? ram_rdata : '0;
    assign ram_raddr = cmd.scan_issue ? scan_idx_reg : sel_idx_reg;

    always_comb
    begin
        rr_pick = (CNT_W'(ptr_reg) >= n_active) ? '0 : ptr_reg;
        rr_ptr_next = ((CNT_W'(rr_pick) + CNT_W'(1)) >= n_active) ? '0
                                                                  : rr_pick + IDX_W'(1);
    end

    always_comb
    begin
        add_sum  = CALC_W'(eff_load) + CALC_W'(amount_reg);
        add_sat  = add_sum > CALC_W'(LOAD_MAX);
        add_load = add_sat ? LOAD_MAX : LOAD_BITS'(add_sum);

        wr_in_range = 32'(target_reg) < 32'(MAX_BACKENDS);
        wr_sat      = CALC_W'(amount_reg) > CALC_W'(LOAD_MAX);
        wr_load     = wr_sat ? LOAD_MAX : LOAD_BITS'(amount_reg);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sel_idx_reg;
        ram_wdata = add_load;
        priority if (cmd.do_add)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.do_write)
        begin
            ram_we    = wr_in_range;
            ram_waddr = IDX_W'(target_reg);
            ram_wdata = wr_load;
        end
    end

    always_comb
    begin
        status.is_write  = (in_action == ACT_WRITE);
        status.policy    = policy_reg;
        status.scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) >= n_active;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_ROUND_ROBIN;
            count_reg     <= COUNT_RESET;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POLICY_MODE:   policy_reg <= policy_t'(cfg_data[0]);
                    CFG_BACKEND_COUNT: count_reg  <= COUNT_W'(cfg_data);
                    default:           count_reg  <= count_reg;
                endcase
            end
            if (cmd.rr_pick)
            begin
                ptr_reg <= rr_ptr_next;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            cmp_pend_reg <= cmd.scan_issue;
            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            target_reg   <= in_target_index;
            amount_reg   <= in_amount;
            scan_idx_reg <= '0;
        end
        if (cmd.scan_issue)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.scan_issue || cmd.sel_read)
        begin
            rd_addr_reg <= ram_raddr;
        end
        if (cmd.rr_pick)
        begin
            sel_idx_reg <= rr_pick;
        end
        // Strict compare keeps the lowest index on ties.
        if (cmp_pend_reg)
        begin
            if ((rd_addr_reg == '0) || (eff_load < best_load_reg))
            begin
                best_load_reg <= eff_load;
                sel_idx_reg   <= rd_addr_reg;
            end
        end
        if (cmd.do_add)
        begin
            res_idx_reg  <= TARGET_W'(sel_idx_reg);
            res_load_reg <= AMOUNT_W'(add_load);
            res_sat_reg  <= add_sat;
        end
        if (cmd.do_write)
        begin
            res_idx_reg  <= target_reg;
            res_load_reg <= wr_in_range ? AMOUNT_W'(wr_load) : '0;
            res_sat_reg  <= wr_in_range && wr_sat;
        end
        if (cmd.out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_load_reg <= res_load_reg;
            out_sat_reg  <= res_sat_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_chosen_backend = out_idx_reg;
    assign out_new_load       = out_load_reg;
    assign out_saturated      = out_sat_reg;
endmodule
